FILE: design/assert_macros.svh
// assertion macros shared by the protected byte memory unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBMU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbmu assertion failed");

// next-cycle implication, checked outside reset
`define PBMU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbmu assertion failed");

`endif

FILE: design/pbmu_pkg.sv
// types and constants of the protected byte memory unit
package pbmu_pkg;

    localparam int NUM_BANKS = 4;
    localparam int BYTE_W    = 8;
    localparam int DATA_W    = NUM_BANKS * BYTE_W;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // access sizes that move data
    localparam logic [2:0] SIZE_MIN = 3'd1;
    localparam logic [2:0] SIZE_MAX = 3'd4;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROM_START      = 3'd0,
        CFG_ROM_LAST       = 3'd1,
        CFG_IO_TABLE_START = 3'd2,
        CFG_IO_AREA_START  = 3'd3
    } t_cfg_idx;

    // reset values of the window registers
    localparam logic [31:0] RST_ROM_START      = 32'd0;
    localparam logic [31:0] RST_ROM_LAST       = 32'd4095;
    localparam logic [31:0] RST_IO_TABLE_START = 32'd4096;
    localparam logic [31:0] RST_IO_AREA_START  = 32'd8192;

    // classified access handed from front to back
    typedef struct packed {
        logic                 is_write;
        logic                 refused;
        logic                 active;
        logic [1:0]           offset;
        logic [2:0]           size;
        logic [NUM_BANKS-1:0] bank_en;
    } t_ctrl;

endpackage

FILE: design/pbmu_ram.sv
// generic single-port ram with registered read
module pbmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pbmu_queue.sv
// two-entry fifo between pipeline parts
`include "assert_macros.svh"
module pbmu_queue import pbmu_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data,
    output logic [1:0]       o_count
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `PBMU_ASSERT_IMP(a_count_bound, 1'b1, r_count <= 2'd2)
    `PBMU_ASSERT_IMP(a_empty_ptrs, r_count == 2'd0, r_wr_ptr == r_rd_ptr)
    `PBMU_ASSERT_IMP(a_full_ptrs, r_count == 2'd2, r_wr_ptr == r_rd_ptr)

endmodule

FILE: design/pbmu_front.sv
// front part: window registers, protection check and byte lane mapping
module pbmu_front import pbmu_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [2:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_cmd,
    input  logic [2:0]                          i_size,
    input  logic [31:0]                         i_address,
    input  logic [DATA_W-1:0]                   i_write_data,
    output t_ctrl                               o_ctrl,
    output logic [NUM_BANKS*(ADDR_BITS-2)-1:0]  o_rows,
    output logic [DATA_W-1:0]                   o_wbytes
);

    localparam int ROW_BITS = ADDR_BITS - 2;

    logic [31:0] r_rom_start;
    logic [31:0] r_rom_last;
    logic [31:0] r_io_table_start;
    logic [31:0] r_io_area_start;

    logic w_protected;
    logic w_size_ok;
    logic w_is_write;
    logic w_refused;
    logic w_active;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_start      <= RST_ROM_START;
            r_rom_last       <= RST_ROM_LAST;
            r_io_table_start <= RST_IO_TABLE_START;
            r_io_area_start  <= RST_IO_AREA_START;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROM_START:      r_rom_start      <= i_cfg_data;
                CFG_ROM_LAST:       r_rom_last       <= i_cfg_data;
                CFG_IO_TABLE_START: r_io_table_start <= i_cfg_data;
                CFG_IO_AREA_START:  r_io_area_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classification on the full unmasked address
    assign w_protected = ((i_address >= r_rom_start) && (i_address <= r_rom_last)) ||
                         ((i_address >= r_io_table_start) && (i_address < r_io_area_start));
    assign w_size_ok   = (i_size >= SIZE_MIN) && (i_size <= SIZE_MAX);
    assign w_is_write  = (i_cmd == CMD_WRITE);
    assign w_refused   = w_is_write && w_protected;
    assign w_active    = w_size_ok && !w_refused;

    // per bank: which byte of the access lands there, and at which row
    always_comb begin
        logic [1:0]           lane;
        logic [ADDR_BITS-1:0] byte_addr;
        o_ctrl.is_write = w_is_write;
        o_ctrl.refused  = w_refused;
        o_ctrl.active   = w_active;
        o_ctrl.offset   = i_address[1:0];
        o_ctrl.size     = i_size;
        o_rows          = '0;
        o_wbytes        = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            lane      = 2'(b) - i_address[1:0];
            byte_addr = i_address[ADDR_BITS-1:0] + ADDR_BITS'(lane);
            o_ctrl.bank_en[b] = w_active && ({1'b0, lane} < i_size);
            o_rows[b*ROW_BITS +: ROW_BITS] = byte_addr[ADDR_BITS-1:2];
            o_wbytes[b*BYTE_W +: BYTE_W]   = i_write_data[lane*BYTE_W +: BYTE_W];
        end
    end

endmodule

FILE: design/pbmu_back.sv
// back part: four byte banks, result assembly and output buffer
`include "assert_macros.svh"
module pbmu_back import pbmu_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  t_ctrl                               i_ctrl,
    input  logic [NUM_BANKS*(ADDR_BITS-2)-1:0]  i_rows,
    input  logic [DATA_W-1:0]                   i_wbytes,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [DATA_W-1:0]                   o_read_data,
    output logic                                o_write_refused
);

    localparam int ROW_BITS = ADDR_BITS - 2;
    localparam int RES_W    = DATA_W + 1;

    logic                 w_issue;
    logic                 r_s1_valid;
    t_ctrl                r_s1_ctrl;
    logic [BYTE_W-1:0]    w_rdata [NUM_BANKS];
    logic [DATA_W-1:0]    w_res_data;
    logic                 w_out_ready;
    logic                 w_out_pop;
    logic [1:0]           w_out_count;
    logic [RES_W-1:0]     w_out_data;

    // issue only with room for the result in flight
    assign w_out_pop = o_valid && i_ready;
    assign o_ready   = ({1'b0, w_out_count} + {2'b00, r_s1_valid}) <= (3'd1 + {2'b00, w_out_pop});
    assign w_issue   = i_valid && o_ready;

    // byte banks
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        pbmu_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (1 << ROW_BITS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_issue && i_ctrl.is_write && i_ctrl.bank_en[b]),
            .i_addr  (i_rows[b*ROW_BITS +: ROW_BITS]),
            .i_wdata (i_wbytes[b*BYTE_W +: BYTE_W]),
            .o_rdata (w_rdata[b])
        );
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_ctrl <= i_ctrl;
        end
    end

    // rotate bank bytes into access order; zero unused lanes, writes and inactive accesses
    always_comb begin
        logic [1:0] bank;
        w_res_data = '0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            bank = r_s1_ctrl.offset + 2'(i);
            if (!r_s1_ctrl.is_write && r_s1_ctrl.active && (3'(i) < r_s1_ctrl.size)) begin
                w_res_data[i*BYTE_W +: BYTE_W] = w_rdata[bank];
            end
        end
    end

    // output buffer
    pbmu_queue #(
        .WIDTH (RES_W)
    ) u_out_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (r_s1_valid),
        .o_push_ready (w_out_ready),
        .i_push_data  ({r_s1_ctrl.refused, w_res_data}),
        .o_pop_valid  (o_valid),
        .i_pop_ready  (i_ready),
        .o_pop_data   (w_out_data),
        .o_count      (w_out_count)
    );

    assign o_read_data     = w_out_data[DATA_W-1:0];
    assign o_write_refused = w_out_data[DATA_W];

    `PBMU_ASSERT_IMP(a_no_overflow, r_s1_valid, w_out_ready)
    `PBMU_ASSERT_IMP(a_write_zero, r_s1_valid && r_s1_ctrl.is_write, w_res_data == '0)
    `PBMU_ASSERT_IMP(a_refused_write, r_s1_valid && r_s1_ctrl.refused,
                     r_s1_ctrl.is_write && !r_s1_ctrl.active)
    `PBMU_ASSERT_NXT(a_issue_reads, w_issue, r_s1_valid)

endmodule

FILE: design/protected_byte_memory_unit.sv
// Byte-addressed memory of 2**ADDR_BITS bytes taking reads and writes of 1 to 4 bytes,
// little-endian, at any alignment, with addresses wrapping in the memory. Writes whose
// full 32-bit address falls in the boot ROM window [rom_start, rom_last] or the I/O table
// window [io_table_start, io_area_start) are dropped and flagged. One access is accepted
// per clock cycle when the result side keeps up; each result goes through the command
// queue, the registered bank read and the output buffer. The rate is set by the four
// byte-wide banks, each with a single port used once per access. Memory contents are
// not cleared: a byte must be written before it is read. The window registers are
// written through the cfg channel, which is always ready; indexes 4 to 7 are ignored.
module protected_byte_memory_unit import pbmu_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // access stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // size[2:0], address[34:3], write_data[66:35], zeros
    input  logic        s_axis_tuser,   // cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_data[31:0]
    output logic        m_axis_tuser    // write_refused
);

    localparam int ROW_BITS = ADDR_BITS - 2;
    localparam int CTRL_W   = $bits(t_ctrl);
    localparam int ENTRY_W  = CTRL_W + NUM_BANKS * ROW_BITS + DATA_W;

    t_ctrl                         w_front_ctrl;
    logic [NUM_BANKS*ROW_BITS-1:0] w_front_rows;
    logic [DATA_W-1:0]             w_front_wbytes;
    logic                          w_q_valid;
    logic                          w_q_ready;
    logic [ENTRY_W-1:0]            w_q_data;
    t_ctrl                         w_back_ctrl;

    assign o_cfg_ready = 1'b1;

    // classify incoming accesses
    pbmu_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (s_axis_tuser),
        .i_size       (s_axis_tdata[2:0]),
        .i_address    (s_axis_tdata[34:3]),
        .i_write_data (s_axis_tdata[66:35]),
        .o_ctrl       (w_front_ctrl),
        .o_rows       (w_front_rows),
        .o_wbytes     (w_front_wbytes)
    );

    // queue between front and back
    pbmu_queue #(
        .WIDTH (ENTRY_W)
    ) u_cmd_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_data  ({w_front_ctrl, w_front_rows, w_front_wbytes}),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_data),
        .o_count      ()
    );

    assign w_back_ctrl = t_ctrl'(w_q_data[ENTRY_W-1 -: CTRL_W]);

    // carry out accesses on the byte banks
    pbmu_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .o_ready         (w_q_ready),
        .i_ctrl          (w_back_ctrl),
        .i_rows          (w_q_data[DATA_W +: NUM_BANKS*ROW_BITS]),
        .i_wbytes        (w_q_data[DATA_W-1:0]),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_read_data     (m_axis_tdata),
        .o_write_refused (m_axis_tuser)
    );

endmodule
